[hdl/pkf_pkg.sv]
package pkf_pkg;

  localparam int unsigned ProgressEntriesDef = 32;
  localparam int unsigned RuleEntriesDef     = 256;
  localparam int unsigned TargetEntriesDef   = 32;

  localparam logic [1:0]  OpPacket  = 2'd0;
  localparam logic [1:0]  OpRule    = 2'd1;
  localparam logic [1:0]  OpTarget  = 2'd2;

  localparam logic [2:0]  ActDrop   = 3'd1;
  localparam logic [2:0]  ActPass   = 3'd2;
  localparam logic [15:0] EthIpv4   = 16'h0800;
  localparam logic [7:0]  ProtoTcp  = 8'd6;
  localparam logic [7:0]  ProtoUdp  = 8'd17;
  localparam logic [15:0] LenEth    = 16'd14;
  localparam logic [15:0] LenIp     = 16'd34;
  localparam logic [15:0] LenL4     = 16'd42;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] frame_length;
    logic [15:0] ethertype;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [15:0] dest_port;
    logic [7:0]  rule_step;
    logic [15:0] rule_last_port;
    logic        rule_opens_target;
    logic [15:0] rule_next_port;
    logic [2:0]  entry_action;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  verdict;
    logic        event_valid;
    logic [7:0]  event_step;
    logic        event_opened;
    logic [15:0] event_next_port;
    logic [15:0] event_port;
    logic [7:0]  event_protocol;
  } out_beat_t;

endpackage

[hdl/port_knock_packet_filter.sv]
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i, in_stall_o   | in_data_i  (in_beat_t)
// out     | output    | out_valid_o, out_stall_i | out_data_o (out_beat_t)
//
// A small sequencer scans one table entry per cycle through a single shared key comparator.
// After reset a clearing pass zeroes every rule key; in_stall_o is high.
// After a beat is accepted: short, non-IPv4, other-protocol frames and the unused op 3 go
// straight to the result; a target write scans the target table; a rule write scans the
// rule keys; a TCP/UDP packet scans the progress, rule and target tables, and on a rule hit
// also writes the target when the rule opens one and the progress entry. The result is held
// while out_stall_i is high, and the next beat is taken in the cycle after it is delivered.
module port_knock_packet_filter
  import pkf_pkg::*;
#(
  parameter int unsigned PROGRESS_ENTRIES = ProgressEntriesDef,
  parameter int unsigned RULE_ENTRIES     = RuleEntriesDef,
  parameter int unsigned TARGET_ENTRIES   = TargetEntriesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int unsigned PW = (PROGRESS_ENTRIES > 1) ? $clog2(PROGRESS_ENTRIES) : 1;
  localparam int unsigned RW = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;
  localparam int unsigned TW = (TARGET_ENTRIES > 1) ? $clog2(TARGET_ENTRIES) : 1;
  localparam int unsigned CW = ((RW > PW) ? ((RW > TW) ? RW : TW) : ((PW > TW) ? PW : TW)) + 1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_PROG, S_RULE, S_RVAL, S_TGT_PUT, S_PRG_PUT,
    S_TGT_FIND, S_TGT_RD, S_RULE_PUT, S_OUT
  } state_e;

  // Progress and target tables: small, kept in flip-flops with valid bits.
  logic                  pv_q [PROGRESS_ENTRIES];
  logic [31:0]           pa_q [PROGRESS_ENTRIES];
  logic [7:0]            ps_q [PROGRESS_ENTRIES];
  logic [15:0]           pl_q [PROGRESS_ENTRIES];
  logic                  tv_q [TARGET_ENTRIES];
  logic [31:0]           ta_q [TARGET_ENTRIES];
  logic [15:0]           tp_q [TARGET_ENTRIES];
  logic [2:0]            tc_q [TARGET_ENTRIES];

  // Rule tables: memories; valid bit stored with the key.
  logic [48:0]           rk_mem [RULE_ENTRIES];
  logic [19:0]           rv_mem [RULE_ENTRIES];
  logic [48:0]           rk_rd_q;
  logic [19:0]           rv_rd_q;

  state_e                state_q;
  in_beat_t              item_q;
  out_beat_t             res_q;
  logic [CW-1:0]         cnt_q;
  logic [CW-1:0]         hit_q;
  logic                  hit_ok_q;
  logic [CW-1:0]         free_q;
  logic                  free_ok_q;
  logic                  p_ok_q;
  logic [PW-1:0]         p_idx_q;
  logic [7:0]            step_q;
  logic [15:0]           last_q;
  logic                  rd_pend_q;
  // Put target parameters.
  logic [15:0]           put_port_q;
  logic [2:0]            put_act_q;
  logic                  opens_q;
  logic [15:0]           next_q;
  logic                  rhit_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = res_q;

  // Result beat that carries only a verdict.
  function automatic out_beat_t verdict_beat(input logic [2:0] verdict);
    out_beat_t b;
    b = '0;
    b.verdict = verdict;
    return b;
  endfunction

  // Shared key compare of the entry under the scan counter.
  logic          cmp_hit;
  logic          cmp_free;
  logic [PW-1:0] pi;
  logic [TW-1:0] ti;
  assign pi = cnt_q[PW-1:0];
  assign ti = cnt_q[TW-1:0];

  always_comb begin
    cmp_hit  = 1'b0;
    cmp_free = 1'b0;
    case (state_q)
      S_PROG, S_PRG_PUT: begin
        cmp_hit  = pv_q[pi] && (pa_q[pi] == item_q.src_addr);
        cmp_free = !pv_q[pi];
      end
      S_TGT_PUT, S_TGT_FIND: begin
        cmp_hit  = tv_q[ti] && (ta_q[ti] == item_q.src_addr) &&
                   (tp_q[ti] == put_port_q);
        cmp_free = !tv_q[ti];
      end
      S_RULE, S_RULE_PUT: begin
        cmp_hit  = rk_rd_q[48] && (rk_rd_q[47:0] == {step_q, item_q.protocol, last_q,
                   item_q.dest_port});
        cmp_free = !rk_rd_q[48];
      end
      default: ;
    endcase
  end

  // Packet result: the verdict of the found target (drop when none is found), plus the event on a rule hit.
  out_beat_t pkt_res;
  always_comb begin
    pkt_res = '0;
    pkt_res.verdict = hit_ok_q ? tc_q[hit_q[TW-1:0]] : ActDrop;
    if (rhit_q) begin
      pkt_res.event_valid     = 1'b1;
      pkt_res.event_step      = step_q;
      pkt_res.event_opened    = opens_q;
      pkt_res.event_next_port = next_q;
      pkt_res.event_port      = item_q.dest_port;
      pkt_res.event_protocol  = item_q.protocol;
    end
  end

  // Rule memory port: read at the scan counter, or at the hit entry in S_RVAL; write at one address.
  logic          rk_we;
  logic [RW-1:0] rk_wa;
  logic [48:0]   rk_wd;
  logic          rv_we;
  logic [RW-1:0] rd_a;
  always_comb begin
    rk_we = 1'b0;
    rk_wa = cnt_q[RW-1:0];
    rk_wd = '0;
    rv_we = 1'b0;
    rd_a  = cnt_q[RW-1:0];
    if (state_q == S_CLEAR) begin
      rk_we = 1'b1;
    end else if (state_q == S_RULE_PUT && rd_pend_q &&
                 cnt_q == CW'(RULE_ENTRIES) + CW'(1)) begin
      rk_we = hit_ok_q || free_ok_q;
      rv_we = rk_we;
      rk_wa = hit_ok_q ? hit_q[RW-1:0] : free_q[RW-1:0];
      rk_wd = {1'b1, item_q.rule_step, item_q.protocol, item_q.rule_last_port,
               item_q.dest_port};
    end else if (state_q == S_RVAL) begin
      rd_a = hit_q[RW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rk_we) rk_mem[rk_wa] <= rk_wd;
    if (rv_we) rv_mem[rk_wa] <= {item_q.rule_opens_target, item_q.rule_next_port,
                                 item_q.entry_action};
    rk_rd_q <= rk_mem[rd_a];
    rv_rd_q <= rv_mem[rd_a];
  end

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      hit_q     <= '0;
      hit_ok_q  <= 1'b0;
      free_q    <= '0;
      free_ok_q <= 1'b0;
      p_ok_q    <= 1'b0;
      p_idx_q   <= '0;
      rd_pend_q <= 1'b0;
      rhit_q    <= 1'b0;
      for (int i = 0; i < PROGRESS_ENTRIES; i++) pv_q[i] <= 1'b0;
      for (int i = 0; i < TARGET_ENTRIES; i++) tv_q[i] <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + CW'(1);
          if (cnt_q == CW'(RULE_ENTRIES - 1)) state_q <= S_IDLE;
        end

        S_IDLE: begin
          cnt_q     <= '0;
          hit_ok_q  <= 1'b0;
          free_ok_q <= 1'b0;
          rd_pend_q <= 1'b0;
          if (in_valid_i) begin
            item_q <= in_data_i;
            case (in_data_i.op)
              OpRule: begin
                res_q   <= '0;
                step_q  <= in_data_i.rule_step;
                last_q  <= in_data_i.rule_last_port;
                state_q <= S_RULE_PUT;
              end
              OpTarget: begin
                res_q      <= '0;
                put_port_q <= in_data_i.dest_port;
                put_act_q  <= in_data_i.entry_action;
                state_q    <= S_TGT_PUT;
              end
              OpPacket: begin
                if (in_data_i.frame_length < LenEth) begin
                  res_q   <= verdict_beat(ActDrop);
                  state_q <= S_OUT;
                end else if (in_data_i.ethertype != EthIpv4) begin
                  res_q   <= verdict_beat(ActPass);
                  state_q <= S_OUT;
                end else if (in_data_i.frame_length < LenIp) begin
                  res_q   <= verdict_beat(ActDrop);
                  state_q <= S_OUT;
                end else if (in_data_i.protocol != ProtoTcp &&
                             in_data_i.protocol != ProtoUdp) begin
                  res_q   <= verdict_beat(ActPass);
                  state_q <= S_OUT;
                end else if (in_data_i.frame_length < LenL4) begin
                  res_q   <= verdict_beat(ActDrop);
                  state_q <= S_OUT;
                end else begin
                  p_ok_q  <= 1'b0;
                  step_q  <= '0;
                  last_q  <= '0;
                  state_q <= S_PROG;
                end
              end
              default: begin
                res_q   <= '0;
                state_q <= S_OUT;
              end
            endcase
          end
        end

        // Find the source's progress entry.
        S_PROG: begin
          if (cmp_hit && !p_ok_q) begin
            p_ok_q  <= 1'b1;
            p_idx_q <= pi;
            step_q  <= ps_q[pi];
            last_q  <= pl_q[pi];
          end
          if (cnt_q == CW'(PROGRESS_ENTRIES - 1)) begin
            cnt_q     <= '0;
            rd_pend_q <= 1'b0;
            state_q   <= S_RULE;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        // Scan the rule keys; memory read data is registered, so it belongs to the previous counter value.
        S_RULE: begin
          if (rd_pend_q && cmp_hit && !hit_ok_q) begin
            hit_ok_q <= 1'b1;
            hit_q    <= cnt_q - CW'(1);
          end
          rd_pend_q <= 1'b1;
          if (cnt_q == CW'(RULE_ENTRIES)) begin
            state_q <= S_RVAL;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_RVAL: begin
          rhit_q <= hit_ok_q;
          if (!hit_ok_q) begin
            if (p_ok_q) pv_q[p_idx_q] <= 1'b0;
            put_port_q <= item_q.dest_port;
            cnt_q      <= '0;
            state_q    <= S_TGT_FIND;
          end else if (rd_pend_q) begin
            // The hit address is presented in this cycle; wait for the registered read data.
            rd_pend_q <= 1'b0;
          end else begin
            opens_q    <= rv_rd_q[19];
            next_q     <= rv_rd_q[18:3];
            put_port_q <= rv_rd_q[18:3];
            put_act_q  <= rv_rd_q[2:0];
            step_q     <= step_q + 8'd1;
            cnt_q      <= '0;
            hit_ok_q   <= 1'b0;
            free_ok_q  <= 1'b0;
            state_q    <= rv_rd_q[19] ? S_TGT_PUT : S_PRG_PUT;
          end
        end

        // Insert or overwrite a target entry.
        S_TGT_PUT: begin
          if (cnt_q == CW'(TARGET_ENTRIES)) begin
            if (hit_ok_q || free_ok_q) begin
              tv_q[hit_ok_q ? hit_q[TW-1:0] : free_q[TW-1:0]] <= 1'b1;
              ta_q[hit_ok_q ? hit_q[TW-1:0] : free_q[TW-1:0]] <= item_q.src_addr;
              tp_q[hit_ok_q ? hit_q[TW-1:0] : free_q[TW-1:0]] <= put_port_q;
              tc_q[hit_ok_q ? hit_q[TW-1:0] : free_q[TW-1:0]] <= put_act_q;
            end
            cnt_q     <= '0;
            hit_ok_q  <= 1'b0;
            free_ok_q <= 1'b0;
            state_q   <= (item_q.op == OpTarget) ? S_OUT : S_PRG_PUT;
          end else begin
            if (cmp_hit && !hit_ok_q) begin
              hit_ok_q <= 1'b1;
              hit_q    <= cnt_q;
            end
            if (cmp_free && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= cnt_q;
            end
            cnt_q <= cnt_q + CW'(1);
          end
        end

        // Insert or overwrite the progress entry.
        S_PRG_PUT: begin
          if (cnt_q == CW'(PROGRESS_ENTRIES)) begin
            if (hit_ok_q || free_ok_q) begin
              pv_q[hit_ok_q ? hit_q[PW-1:0] : free_q[PW-1:0]] <= 1'b1;
              pa_q[hit_ok_q ? hit_q[PW-1:0] : free_q[PW-1:0]] <= item_q.src_addr;
              ps_q[hit_ok_q ? hit_q[PW-1:0] : free_q[PW-1:0]] <= step_q;
              pl_q[hit_ok_q ? hit_q[PW-1:0] : free_q[PW-1:0]] <= item_q.dest_port;
            end
            cnt_q      <= '0;
            hit_ok_q   <= 1'b0;
            put_port_q <= item_q.dest_port;
            state_q    <= S_TGT_FIND;
          end else begin
            if (cmp_hit && !hit_ok_q) begin
              hit_ok_q <= 1'b1;
              hit_q    <= cnt_q;
            end
            if (cmp_free && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= cnt_q;
            end
            cnt_q <= cnt_q + CW'(1);
          end
        end

        // Look up the verdict target.
        S_TGT_FIND: begin
          if (cmp_hit && !hit_ok_q) begin
            hit_ok_q <= 1'b1;
            hit_q    <= cnt_q;
          end
          if (cnt_q == CW'(TARGET_ENTRIES - 1)) begin
            state_q <= S_TGT_RD;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_TGT_RD: begin
          res_q   <= pkt_res;
          state_q <= S_OUT;
        end

        // Rule write: scan keys through the registered memory read, then write.
        S_RULE_PUT: begin
          if (rd_pend_q && cnt_q <= CW'(RULE_ENTRIES)) begin
            if (cmp_hit && !hit_ok_q) begin
              hit_ok_q <= 1'b1;
              hit_q    <= cnt_q - CW'(1);
            end
            if (cmp_free && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= cnt_q - CW'(1);
            end
          end
          rd_pend_q <= 1'b1;
          if (cnt_q == CW'(RULE_ENTRIES) + CW'(1)) begin
            state_q <= S_OUT;
          end else begin
            cnt_q <= cnt_q + CW'(1);
          end
        end

        S_OUT: begin
          rhit_q <= 1'b0;
          if (!out_stall_i) state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
